[rtl/sfcs_pkg.sv]
// ----------------------------------------------------------------------------
// sfcs_pkg
// Shared codes, flash command bytes and the job descriptor passed between the
// front and back parts of the serial flash command sequencer.
// ----------------------------------------------------------------------------
package sfcs_pkg;

  // request operation codes
  localparam logic [2:0] OP_READ_ID = 3'd0;
  localparam logic [2:0] OP_READ    = 3'd1;
  localparam logic [2:0] OP_PROGRAM = 3'd2;
  localparam logic [2:0] OP_SECTOR  = 3'd3;
  localparam logic [2:0] OP_CHIP    = 3'd4;
  localparam logic [2:0] OP_DATA    = 3'd5;
  localparam logic [2:0] OP_RX      = 3'd6;

  // flash command and filler bytes
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_SE    = 8'h20;
  localparam logic [7:0] CMD_CE    = 8'hC7;
  localparam logic [7:0] CMD_RDID  = 8'h9F;
  localparam logic [7:0] DUMMY     = 8'hFF;
  localparam logic [7:0] MFR_A     = 8'hEF;
  localparam logic [7:0] MFR_B     = 8'hC8;
  localparam logic [7:0] MFR_C     = 8'h1F;
  localparam int         BUSY_BIT  = 0;

  // page size and the clamp value at length width
  localparam int          PAGE_BYTES = 256;
  localparam logic [15:0] PAGE_LEN   = 16'(PAGE_BYTES);

  // job kinds handed from front to back
  localparam logic [3:0] J_ID     = 4'd0;
  localparam logic [3:0] J_REJ    = 4'd1;
  localparam logic [3:0] J_READ   = 4'd2;
  localparam logic [3:0] J_PROG   = 4'd3;
  localparam logic [3:0] J_SECTOR = 4'd4;
  localparam logic [3:0] J_CHIP   = 4'd5;
  localparam logic [3:0] J_DATA   = 4'd6;
  localparam logic [3:0] J_IDBYTE = 4'd7;
  localparam logic [3:0] J_RDBYTE = 4'd8;
  localparam logic [3:0] J_STATUS = 4'd9;

  // queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // flag_a / flag_b meaning depends on kind:
  //   read:   a = zero length, b = length one
  //   prog:   a = zero count
  //   data:   a = frame ends here, b = polling follows
  //   idbyte: a = last id byte
  //   rdbyte: a = final byte, b = one byte left after this
  //   status: a = busy
  typedef struct packed {
    logic [3:0]  kind;
    logic [23:0] address;
    logic [7:0]  data_byte;
    logic        flag_a;
    logic        flag_b;
    logic        id_ok;
  } job_t;

endpackage

[rtl/sfcs_if.sv]
// ----------------------------------------------------------------------------
// sfcs_req_if / sfcs_rsp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface sfcs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [23:0] address;
  logic [15:0] length;
  logic [7:0]  data_byte;

  modport source (output valid, output op, output address, output length,
                  output data_byte, input ready);
  modport sink   (input valid, input op, input address, input length,
                  input data_byte, output ready);
endinterface

interface sfcs_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       select_active;
  logic       capture_reply;
  logic       frame_end;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       id_ok;
  logic       rejected;
  logic       done_res;
  logic       last;

  modport source (output valid, output spi_byte, output select_active,
                  output capture_reply, output frame_end, output read_valid,
                  output read_byte, output id_ok, output rejected,
                  output done_res, output last, input ready);
  modport sink   (input valid, input spi_byte, input select_active,
                  input capture_reply, input frame_end, input read_valid,
                  input read_byte, input id_ok, input rejected,
                  input done_res, input last, output ready);
endinterface

[rtl/sfcs_front.sv]
// ----------------------------------------------------------------------------
// sfcs_front
// Accepts request beats, tracks the command phase and the verified flag, and
// turns each beat that causes results into one job for the back part.
// ----------------------------------------------------------------------------
module sfcs_front
  import sfcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [2:0]  op,
  input  logic [23:0] address,
  input  logic [15:0] length,
  input  logic [7:0]  data_byte,
  input  logic        space,
  output logic        push,
  output job_t        push_job
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ID   = 3'd1;
  localparam logic [2:0] PH_READ = 3'd2;
  localparam logic [2:0] PH_PROG = 3'd3;
  localparam logic [2:0] PH_POLL = 3'd4;

  logic [2:0]  phase, phase_next;
  logic        device_ok, device_ok_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [1:0]  id_index, id_index_next;

  logic        idle;
  logic        emit;
  logic        accept;
  logic [15:0] count;
  logic [15:0] left_dec;
  logic        mfr_match;

  assign idle      = (phase == PH_IDLE);
  assign count     = (length > PAGE_LEN) ? PAGE_LEN : length;
  assign left_dec  = (bytes_left != 16'd0) ? bytes_left - 16'd1 : 16'd0;
  assign mfr_match = (data_byte == MFR_A) || (data_byte == MFR_B) || (data_byte == MFR_C);
  assign accept    = in_valid && space;

  // classify the beat and work out the next state
  always_comb begin
    phase_next      = phase;
    device_ok_next  = device_ok;
    bytes_left_next = bytes_left;
    id_index_next   = id_index;
    emit            = 1'b0;
    push_job        = '0;
    push_job.address   = address;
    push_job.data_byte = data_byte;
    case (op)
      OP_READ_ID, OP_READ, OP_PROGRAM, OP_SECTOR, OP_CHIP: begin
        if (idle) begin
          emit = 1'b1;
          if (op == OP_READ_ID) begin
            push_job.kind = J_ID;
            phase_next    = PH_ID;
            id_index_next = 2'd0;
          end else if (!device_ok) begin
            push_job.kind = J_REJ;
          end else if (op == OP_READ) begin
            push_job.kind   = J_READ;
            push_job.flag_a = (length == 16'd0);
            push_job.flag_b = (length == 16'd1);
            if (length != 16'd0) begin
              bytes_left_next = length;
              phase_next      = PH_READ;
            end
          end else if (op == OP_PROGRAM) begin
            push_job.kind   = J_PROG;
            push_job.flag_a = (count == 16'd0);
            if (count == 16'd0) begin
              phase_next = PH_POLL;
            end else begin
              bytes_left_next = count;
              phase_next      = PH_PROG;
            end
          end else if (op == OP_SECTOR) begin
            push_job.kind = J_SECTOR;
            phase_next    = PH_POLL;
          end else begin
            push_job.kind = J_CHIP;
            phase_next    = PH_POLL;
          end
        end
      end
      OP_DATA: begin
        if (phase == PH_PROG) begin
          emit            = 1'b1;
          push_job.kind   = J_DATA;
          push_job.flag_a = (bytes_left <= 16'd1);
          push_job.flag_b = (left_dec == 16'd0);
          bytes_left_next = left_dec;
          if (left_dec == 16'd0) phase_next = PH_POLL;
        end
      end
      OP_RX: begin
        if (phase == PH_ID) begin
          emit            = 1'b1;
          push_job.kind   = J_IDBYTE;
          push_job.flag_a = (id_index >= 2'd2);
          if (id_index == 2'd0) device_ok_next = mfr_match;
          if (id_index >= 2'd2) begin
            phase_next    = PH_IDLE;
            id_index_next = 2'd0;
          end else begin
            id_index_next = id_index + 2'd1;
          end
        end else if (phase == PH_READ) begin
          emit            = 1'b1;
          push_job.kind   = J_RDBYTE;
          push_job.flag_a = (left_dec == 16'd0);
          push_job.flag_b = (left_dec == 16'd1);
          bytes_left_next = left_dec;
          if (left_dec == 16'd0) phase_next = PH_IDLE;
        end else if (phase == PH_POLL) begin
          emit            = 1'b1;
          push_job.kind   = J_STATUS;
          push_job.flag_a = data_byte[BUSY_BIT];
          if (!data_byte[BUSY_BIT]) phase_next = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
    push_job.id_ok = device_ok_next;
  end

  assign push = accept && emit;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      device_ok  <= 1'b0;
      bytes_left <= 16'd0;
      id_index   <= 2'd0;
    end else if (accept) begin
      phase      <= phase_next;
      device_ok  <= device_ok_next;
      bytes_left <= bytes_left_next;
      id_index   <= id_index_next;
    end
  end

  // id bytes are counted only while reading the id
  a_id_index: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_ID) |-> (id_index == 2'd0))
    else $error("id index left non-zero outside id phase");

  // a program data phase always has bytes to go
  a_prog_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PROG) |-> (bytes_left != 16'd0))
    else $error("program phase with no bytes left");

endmodule

[rtl/sfcs_queue.sv]
// ----------------------------------------------------------------------------
// sfcs_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module sfcs_queue
  import sfcs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic space,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign space     = (count != QCNT_W'(QDEPTH));
  assign pop_valid = (count != '0);
  assign do_push   = push && space;
  assign do_pop    = pop && pop_valid;
  assign pop_job   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop)      count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

  // fill count stays within depth
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue overfilled");

  // pointer gap matches fill count
  a_ptrs: assert property (@(posedge clk) disable iff (rst)
    QPTR_W'(count) == QPTR_W'(wr_ptr - rd_ptr))
    else $error("queue pointers out of step with count");

endmodule

[rtl/sfcs_back.sv]
// ----------------------------------------------------------------------------
// sfcs_back
// Expands one job into its result beats, one beat a cycle while rsp.ready is
// high, and pulls the next job from the queue as the last beat leaves.
// ----------------------------------------------------------------------------
module sfcs_back
  import sfcs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic pop_valid,
  output logic pop,
  input  job_t pop_job,
  sfcs_rsp_if.source rsp
);

  job_t       job;
  logic       loaded;
  logic [2:0] step;
  logic       beat_last;
  logic       take;

  assign rsp.valid = loaded;
  assign rsp.last  = beat_last;
  assign rsp.id_ok = job.id_ok;
  assign take      = loaded && rsp.ready;
  assign pop       = pop_valid && (!loaded || (take && beat_last));

  // beat contents for the current job and step
  always_comb begin
    rsp.spi_byte      = 8'd0;
    rsp.select_active = 1'b0;
    rsp.capture_reply = 1'b0;
    rsp.frame_end     = 1'b0;
    rsp.read_valid    = 1'b0;
    rsp.read_byte     = 8'd0;
    rsp.rejected      = 1'b0;
    rsp.done_res      = 1'b0;
    beat_last         = 1'b0;
    case (job.kind)
      J_ID: begin
        rsp.select_active = 1'b1;
        case (step)
          3'd0:    rsp.spi_byte = CMD_RDID;
          3'd1, 3'd2: begin
            rsp.spi_byte      = DUMMY;
            rsp.capture_reply = 1'b1;
          end
          default: begin
            rsp.spi_byte      = DUMMY;
            rsp.capture_reply = 1'b1;
            rsp.frame_end     = 1'b1;
            beat_last         = 1'b1;
          end
        endcase
      end
      J_READ: begin
        rsp.select_active = 1'b1;
        case (step)
          3'd0: rsp.spi_byte = CMD_READ;
          3'd1: rsp.spi_byte = job.address[23:16];
          3'd2: rsp.spi_byte = job.address[15:8];
          3'd3: begin
            rsp.spi_byte  = job.address[7:0];
            rsp.frame_end = job.flag_a;
            rsp.done_res  = job.flag_a;
            beat_last     = job.flag_a;
          end
          default: begin
            rsp.spi_byte      = DUMMY;
            rsp.capture_reply = 1'b1;
            rsp.frame_end     = job.flag_b;
            beat_last         = 1'b1;
          end
        endcase
      end
      J_PROG, J_SECTOR: begin
        rsp.select_active = 1'b1;
        case (step)
          3'd0: begin
            rsp.spi_byte  = CMD_WREN;
            rsp.frame_end = 1'b1;
          end
          3'd1: rsp.spi_byte = (job.kind == J_PROG) ? CMD_PP : CMD_SE;
          3'd2: rsp.spi_byte = job.address[23:16];
          3'd3: rsp.spi_byte = job.address[15:8];
          3'd4: begin
            rsp.spi_byte  = job.address[7:0];
            rsp.frame_end = (job.kind == J_SECTOR) || job.flag_a;
            beat_last     = (job.kind == J_PROG) && !job.flag_a;
          end
          3'd5: rsp.spi_byte = CMD_RDSR;
          default: begin
            rsp.spi_byte      = DUMMY;
            rsp.capture_reply = 1'b1;
            rsp.frame_end     = 1'b1;
            beat_last         = 1'b1;
          end
        endcase
      end
      J_CHIP: begin
        rsp.select_active = 1'b1;
        case (step)
          3'd0: begin
            rsp.spi_byte  = CMD_WREN;
            rsp.frame_end = 1'b1;
          end
          3'd1: begin
            rsp.spi_byte  = CMD_CE;
            rsp.frame_end = 1'b1;
          end
          3'd2: rsp.spi_byte = CMD_RDSR;
          default: begin
            rsp.spi_byte      = DUMMY;
            rsp.capture_reply = 1'b1;
            rsp.frame_end     = 1'b1;
            beat_last         = 1'b1;
          end
        endcase
      end
      J_DATA: begin
        rsp.select_active = 1'b1;
        case (step)
          3'd0: begin
            rsp.spi_byte  = job.data_byte;
            rsp.frame_end = job.flag_a;
            beat_last     = !job.flag_b;
          end
          3'd1: rsp.spi_byte = CMD_RDSR;
          default: begin
            rsp.spi_byte      = DUMMY;
            rsp.capture_reply = 1'b1;
            rsp.frame_end     = 1'b1;
            beat_last         = 1'b1;
          end
        endcase
      end
      J_IDBYTE: begin
        rsp.read_valid = 1'b1;
        rsp.read_byte  = job.data_byte;
        rsp.done_res   = job.flag_a;
        beat_last      = 1'b1;
      end
      J_RDBYTE: begin
        rsp.read_valid = 1'b1;
        rsp.read_byte  = job.data_byte;
        beat_last      = 1'b1;
        if (job.flag_a) begin
          rsp.done_res = 1'b1;
        end else begin
          rsp.spi_byte      = DUMMY;
          rsp.select_active = 1'b1;
          rsp.capture_reply = 1'b1;
          rsp.frame_end     = job.flag_b;
        end
      end
      J_STATUS: begin
        if (job.flag_a) begin
          rsp.select_active = 1'b1;
          if (step == 3'd0) begin
            rsp.spi_byte = CMD_RDSR;
          end else begin
            rsp.spi_byte      = DUMMY;
            rsp.capture_reply = 1'b1;
            rsp.frame_end     = 1'b1;
            beat_last         = 1'b1;
          end
        end else begin
          rsp.done_res = 1'b1;
          beat_last    = 1'b1;
        end
      end
      default: begin
        // rejected command
        rsp.rejected = 1'b1;
        rsp.done_res = 1'b1;
        beat_last    = 1'b1;
      end
    endcase
  end

  // current job register
  always_ff @(posedge clk) begin
    if (pop) job <= pop_job;
  end

  // load flag and beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      step   <= 3'd0;
    end else if (pop) begin
      loaded <= 1'b1;
      step   <= 3'd0;
    end else if (take) begin
      if (beat_last) begin
        loaded <= 1'b0;
        step   <= 3'd0;
      end else begin
        step <= step + 3'd1;
      end
    end
  end

  // no job runs past seven beats
  a_step: assert property (@(posedge clk) disable iff (rst)
    loaded |-> (step <= 3'd6))
    else $error("beat counter ran past the longest job");

  // a job ends with its last beat before the next is loaded
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && loaded) |-> (take && beat_last))
    else $error("job replaced before its last beat");

endmodule

[rtl/spi_flash_command_sequencer_top.sv]
// Flow: a request beat that causes results is written into the job queue, then popped into
// the back part's job register; result beats then follow one per cycle while rsp.ready is high.
// Throughput: one request beat a cycle while the four-entry job queue has room; the back
// part gives one result beat a cycle while rsp.ready is high (up to seven per request), loading jobs back to back.
// Reset: synchronous rst clears the phase, the verified flag, the counters and the queue.
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer_top
// Host-side serial NOR flash command sequencer: front classifier, job queue
// and beat generator.
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer_top
  import sfcs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  sfcs_req_if.sink   req,
  sfcs_rsp_if.source rsp
);

  logic space;
  logic push;
  job_t push_job;
  logic pop_valid;
  logic pop;
  job_t pop_job;

  assign req.ready = space;

  // request classification
  sfcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .op        (req.op),
    .address   (req.address),
    .length    (req.length),
    .data_byte (req.data_byte),
    .space     (space),
    .push      (push),
    .push_job  (push_job)
  );

  // job queue
  sfcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .space     (space),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_job   (pop_job)
  );

  // beat generation
  sfcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_job   (pop_job),
    .rsp       (rsp)
  );

endmodule
